FILE: design/sosg_pkg.sv
// ----------------------------------------------------------------------------
// sosg_pkg: shared types, constants and round-function helpers
// Widths, allocator constants, control structs and the mixing steps of the
// 28-bit Feistel round used by the scrambled object ID generator.
// ----------------------------------------------------------------------------
package sosg_pkg;

    // field and datapath widths
    localparam int ID_W     = 64;
    localparam int TYPE_W   = 8;
    localparam int HALF_W   = 28;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int NUM_ROUNDS = 4;
    localparam int ROUND_W  = $clog2(NUM_ROUNDS);
    localparam int PAYLOAD_W = 2 * HALF_W;

    // allocator constants
    localparam logic [ID_W-1:0] ID_STRIDE  = 64'd7;
    localparam logic [ID_W-1:0] BLOCK_LEN  = 64'd4096;
    localparam logic [ID_W-1:0] BASE_RESET = 64'd1;

    // fmix32 multipliers
    localparam logic [KEY_W-1:0] MUL_C1 = 32'h85eb_ca6b;
    localparam logic [KEY_W-1:0] MUL_C2 = 32'hc2b2_ae35;

    // last round index
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

    // round keys as one packed vector, one key per round
    typedef logic [NUM_ROUNDS-1:0][KEY_W-1:0] t_key_arr;

    // controller state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RND_A = 4'b0010,
        ST_RND_B = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_sosg_state;

    // controller to datapath commands
    typedef struct packed {
        logic               load;      // accept request, allocate an ID
        logic               mul1;      // first multiply of the round
        logic               mul2;      // second multiply, update halves
        logic               out_load;  // write the output register
        logic [ROUND_W-1:0] round;     // current round index
    } t_sosg_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;                // output register can take a result
    } t_sosg_status;

    // key mix and first shift-xor of fmix32
    function automatic logic [KEY_W-1:0] fmix_pre(input logic [HALF_W-1:0] half,
                                                  input logic [KEY_W-1:0]  key);
        logic [KEY_W-1:0] v;
        v = {{(KEY_W-HALF_W){1'b0}}, half} ^ key;
        return v ^ (v >> 16);
    endfunction

    // middle shift-xor of fmix32
    function automatic logic [KEY_W-1:0] fmix_mid(input logic [KEY_W-1:0] p);
        return p ^ (p >> 13);
    endfunction

    // last shift-xor of fmix32, kept to a half
    function automatic logic [HALF_W-1:0] fmix_post(input logic [KEY_W-1:0] p);
        logic [KEY_W-1:0] v;
        v = p ^ (p >> 16);
        return v[HALF_W-1:0];
    endfunction

endpackage

FILE: design/sosg_regs.sv
// ----------------------------------------------------------------------------
// sosg_regs: round key register file
// APB-style write/read access to the four 32-bit Feistel round keys.
// ----------------------------------------------------------------------------
module sosg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sosg_pkg::ADDR_W-1:0]   paddr,
    input  logic [sosg_pkg::DATA_W-1:0]   pwdata,
    output logic [sosg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sosg_pkg::t_key_arr            o_keys
);

    sosg_pkg::t_key_arr                 r_keys;
    logic [sosg_pkg::ROUND_W-1:0]       w_idx;
    logic                               w_wr;

    // word index and write strobe
    assign w_idx = paddr[sosg_pkg::ADDR_W-1:2];
    assign w_wr  = psel & penable & pwrite;

    // key storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (w_wr) begin
            r_keys[w_idx] <= pwdata;
        end
    end

    // read back, no wait states
    assign prdata = r_keys[w_idx];
    assign pready = 1'b1;
    assign o_keys = r_keys;

endmodule

FILE: design/sosg_ctrl.sv
// ----------------------------------------------------------------------------
// sosg_ctrl: request sequencer
// Accepts a request, steps four Feistel rounds, each through ST_RND_A and
// ST_RND_B, and hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module sosg_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  sosg_pkg::t_sosg_status i_status,
    output sosg_pkg::t_sosg_cmd    o_cmd
);

    sosg_pkg::t_sosg_state          r_state, n_state;
    logic [sosg_pkg::ROUND_W-1:0]   r_round, n_round;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_round      = r_round;
        o_cmd        = '0;
        o_cmd.round  = r_round;
        o_in_ready   = 1'b0;
        unique case (r_state)
            sosg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_state    = sosg_pkg::ST_RND_A;
                end
            end
            sosg_pkg::ST_RND_A: begin
                o_cmd.mul1 = 1'b1;
                n_state    = sosg_pkg::ST_RND_B;
            end
            sosg_pkg::ST_RND_B: begin
                o_cmd.mul2 = 1'b1;
                if (r_round != sosg_pkg::LAST_ROUND) begin
                    n_round = r_round + 1'b1;
                    n_state = sosg_pkg::ST_RND_A;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sosg_pkg::ST_IDLE;
                end else begin
                    n_state = sosg_pkg::ST_HOLD;
                end
            end
            sosg_pkg::ST_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sosg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sosg_pkg::ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sosg_pkg::ST_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

`ifndef ASSERT_OFF
    // a result is only written after the last round
    a_out_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_round == sosg_pkg::LAST_ROUND))
        else $error("output written before last round");

    // each first multiply is followed by its second
    a_rnd_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul1 |=> o_cmd.mul2)
        else $error("round half skipped");
`endif

endmodule

FILE: design/sosg_dp.sv
// ----------------------------------------------------------------------------
// sosg_dp: allocator and Feistel datapath
// Block allocator, 28-bit half registers, the two-stage fmix32 round
// function and the output register.
// ----------------------------------------------------------------------------
module sosg_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sosg_pkg::t_sosg_cmd            i_cmd,
    output sosg_pkg::t_sosg_status         o_status,
    input  sosg_pkg::t_key_arr             i_keys,
    input  logic [sosg_pkg::TYPE_W-1:0]    i_object_type,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sosg_pkg::ID_W-1:0]      o_object_id
);

    // allocator state
    logic [sosg_pkg::ID_W-1:0]   r_next_base;
    logic [sosg_pkg::ID_W-1:0]   r_running;
    logic [sosg_pkg::ID_W-1:0]   r_limit;

    // round state
    logic [sosg_pkg::TYPE_W-1:0] r_type;
    logic [sosg_pkg::HALF_W-1:0] r_left;
    logic [sosg_pkg::HALF_W-1:0] r_right;
    logic [sosg_pkg::KEY_W-1:0]  r_prod;

    // output register
    logic                        r_out_valid;
    logic [sosg_pkg::ID_W-1:0]   r_out_id;

    logic [sosg_pkg::ID_W-1:0]   w_run_step;
    logic [sosg_pkg::ID_W-1:0]   w_base_step;
    logic [sosg_pkg::ID_W-1:0]   w_base_next;
    logic                        w_claim;
    logic [sosg_pkg::ID_W-1:0]   w_id;
    logic [sosg_pkg::KEY_W-1:0]  w_p1;
    logic [sosg_pkg::KEY_W-1:0]  w_p2;
    logic [sosg_pkg::HALF_W-1:0] w_new_right;
    logic [sosg_pkg::ID_W-1:0]   w_out_id;

    // block check and ID selection, three adders in parallel
    assign w_run_step  = r_running + sosg_pkg::ID_STRIDE;
    assign w_base_step = r_next_base + sosg_pkg::ID_STRIDE;
    assign w_base_next = r_next_base + sosg_pkg::BLOCK_LEN;
    assign w_claim     = (w_run_step >= r_limit);
    assign w_id        = w_claim ? r_next_base : r_running;

    // round function, split at the multipliers
    assign w_p1        = sosg_pkg::fmix_pre(r_right, i_keys[i_cmd.round]) * sosg_pkg::MUL_C1;
    assign w_p2        = sosg_pkg::fmix_mid(r_prod) * sosg_pkg::MUL_C2;
    assign w_new_right = r_left ^ sosg_pkg::fmix_post(w_p2);

    // result straight from the last round or from the held halves
    assign w_out_id = i_cmd.mul2 ? {r_type, r_right, w_new_right}
                                 : {r_type, r_left, r_right};

    // allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_base <= sosg_pkg::BASE_RESET;
            r_running   <= '0;
            r_limit     <= '0;
        end else if (i_cmd.load) begin
            r_running <= w_claim ? w_base_step : w_run_step;
            if (w_claim) begin
                r_limit     <= w_base_next;
                r_next_base <= w_base_next;
            end
        end
    end

    // Feistel halves and product register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_object_type;
            r_left  <= w_id[sosg_pkg::PAYLOAD_W-1:sosg_pkg::HALF_W];
            r_right <= w_id[sosg_pkg::HALF_W-1:0];
        end else if (i_cmd.mul2) begin
            r_left  <= r_right;
            r_right <= w_new_right;
        end
        if (i_cmd.mul1) begin
            r_prod <= w_p1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_id <= w_out_id;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_object_id       = r_out_id;

`ifndef ASSERT_OFF
    // never overwrite a result that is not being taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output overwritten");

    // the global base only moves by one block, and only on a claim
    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_next_base == $past(r_next_base)) ||
                       (r_next_base == $past(r_next_base) + sosg_pkg::BLOCK_LEN))
        else $error("block base jumped");
`endif

endmodule

FILE: design/scrambled_object_id_generator_core.sv
// ----------------------------------------------------------------------------
// scrambled_object_id_generator_core: scrambled object ID generator
// Hands out 64-bit object IDs: type in the top byte, a block-allocated
// running ID permuted by a keyed 4-round Feistel network below.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_object_type): one request per
//    transaction. Output channel (o_out_valid / i_out_ready / o_object_id):
//    one ID per request, in request order.
//  - Round keys are written over the APB port (byte addresses 0, 4, 8, 12)
//    while no request is in flight; they reset to zero.
//  - Each Feistel round steps through the ST_RND_A and ST_RND_B states,
//    split at the two registered fmix32 multipliers.
//  - The sequencer takes requests one at a time: a new request is taken
//    only in ST_IDLE, once the previous ID has gone to the output register.
//  - A finished ID sits in the output register; a stalled receiver delays
//    the next result's write-back, and no new request is accepted meanwhile.
//  - Reset (synchronous, active low) empties the output register, sets the
//    block base to 1 and the running ID and block limit to 0, so the first
//    request claims a fresh block spanning 4096 ID values.
// ----------------------------------------------------------------------------
module scrambled_object_id_generator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sosg_pkg::ADDR_W-1:0]   paddr,
    input  logic [sosg_pkg::DATA_W-1:0]   pwdata,
    output logic [sosg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sosg_pkg::TYPE_W-1:0]   i_object_type,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sosg_pkg::ID_W-1:0]     o_object_id
);

    sosg_pkg::t_key_arr       w_keys;
    sosg_pkg::t_sosg_cmd      w_cmd;
    sosg_pkg::t_sosg_status   w_status;

    // round key registers
    sosg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keys  (w_keys)
    );

    // sequencer
    sosg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // allocator and Feistel datapath
    sosg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_keys        (w_keys),
        .i_object_type (i_object_type),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_object_id   (o_object_id)
    );

endmodule
